// ----- hdl/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and codes of the binary min-heap queue: request and result
// payloads, the classified command passed from front to engine, engine states.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_LOAD,
    ST_DOWN,
    ST_FINAL
  } eng_state_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_key;
    logic               top_valid;
    logic [10:0]        entry_count;
    status_e            status;
  } out_item_t;

  // Classified command from front to engine.
  typedef struct packed {
    op_e     op;
    status_e status;
  } cmd_t;

endpackage

// ----- hdl/bmhq_front.sv -----
// ----------------------------------------------------------------------------
// bmhq_front
// Accepts requests, classifies them against a predicted fill level and holds
// them in a two-entry command queue for the engine.
// ----------------------------------------------------------------------------
module bmhq_front #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  bmhq_pkg::in_item_t     in_item_i,
  output logic                   full_o,
  output logic                   cmd_valid_o,
  output bmhq_pkg::cmd_t         cmd_o,
  output logic [KEY_WIDTH-1:0]   cmd_key_o,
  input  logic                   cmd_take_i
);
  import bmhq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cmd_t                 q_cmd_q [2];
  logic [KEY_WIDTH-1:0] q_key_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           q_cnt_q, q_cnt_d;
  logic [CNT_W-1:0]     pred_cnt_q, pred_cnt_d;
  logic                 accept;
  cmd_t                 new_cmd;
  logic [KEY_WIDTH-1:0] new_key;

  assign full_o      = (q_cnt_q == 2'd2);
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = (q_cnt_q != 2'd0);
  assign cmd_o       = q_cmd_q[rd_ptr_q];
  assign cmd_key_o   = q_key_q[rd_ptr_q];
  assign new_key     = KEY_WIDTH'(in_item_i.key_in);

  // Classify against the fill level the heap will have once earlier requests land
  always_comb begin
    new_cmd    = '{op: OP_NONE, status: STATUS_OK};
    pred_cnt_d = pred_cnt_q;
    if (in_item_i.mode == MODE_PUSH) begin
      if (pred_cnt_q == CNT_W'(CAPACITY)) begin
        new_cmd.status = STATUS_PUSH_FULL;
      end else begin
        new_cmd.op = OP_PUSH;
        pred_cnt_d = pred_cnt_q + 1'b1;
      end
    end else begin
      if (pred_cnt_q == '0) begin
        new_cmd.status = STATUS_POP_EMPTY;
      end else begin
        new_cmd.op = OP_POP;
        pred_cnt_d = pred_cnt_q - 1'b1;
      end
    end
  end

  assign q_cnt_d = 2'(q_cnt_q + {1'b0, accept} - {1'b0, cmd_take_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      q_cnt_q    <= '0;
      pred_cnt_q <= '0;
    end else begin
      q_cnt_q <= q_cnt_d;
      if (accept) begin
        wr_ptr_q   <= !wr_ptr_q;
        pred_cnt_q <= pred_cnt_d;
      end
      if (cmd_take_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_cmd_q[wr_ptr_q] <= new_cmd;
      q_key_q[wr_ptr_q] <= new_key;
    end
  end

endmodule

// ----- hdl/bmhq_engine.sv -----
// ----------------------------------------------------------------------------
// bmhq_engine
// Carries out heap commands on the key store: sift-up for push, sift-down for
// pop, one level per cycle, and queues results in a two-entry output queue.
// ----------------------------------------------------------------------------
module bmhq_engine #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  bmhq_pkg::cmd_t         cmd_i,
  input  logic [KEY_WIDTH-1:0]   cmd_key_i,
  output logic                   cmd_take_o,
  output logic                   empty_o,
  output bmhq_pkg::out_item_t    out_item_o,
  input  logic                   pop_i
);
  import bmhq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CH_W  = IDX_W + 2;

  // key store
  logic signed [KEY_WIDTH-1:0] mem [CAPACITY];
  logic signed [KEY_WIDTH-1:0] rd_a_q, rd_b_q;
  logic                        we, re_a, re_b;
  logic [IDX_W-1:0]            waddr, raddr_a, raddr_b;
  logic signed [KEY_WIDTH-1:0] wdata;

  eng_state_e                  state_q, state_d;
  logic [IDX_W-1:0]            pos_q, pos_d;
  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic signed [KEY_WIDTH-1:0] root_q, root_d;

  logic                        done;
  status_e                     done_status;
  out_item_t                   res_item;

  out_item_t                   res_q [2];
  logic                        res_wr_q, res_rd_q;
  logic [1:0]                  res_cnt_q;
  logic                        res_pop;

  logic [IDX_W-1:0]            parent;
  logic [CH_W-1:0]             left, right, cnt_ext;
  logic                        l_ok, r_ok, take_l, take_r;
  logic [IDX_W-1:0]            best;
  logic signed [KEY_WIDTH-1:0] best_val;
  logic [CH_W-1:0]             nleft;

  assign parent  = IDX_W'((pos_q - 1'b1) >> 1);
  assign left    = CH_W'({pos_q, 1'b1});
  assign right   = left + 1'b1;
  assign cnt_ext = CH_W'(cnt_q);
  assign l_ok    = (left < cnt_ext);
  assign r_ok    = (right < cnt_ext);

  // Smaller child; right wins only when strictly below the running minimum
  always_comb begin
    take_l   = l_ok && (key_q > rd_a_q);
    best     = pos_q;
    best_val = key_q;
    if (take_l) begin
      best     = left[IDX_W-1:0];
      best_val = rd_a_q;
    end
    take_r = r_ok && (best_val > rd_b_q);
    if (take_r) begin
      best     = right[IDX_W-1:0];
      best_val = rd_b_q;
    end
  end

  assign nleft = CH_W'({best, 1'b1});

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = key_q;
    re_a        = 1'b0;
    re_b        = 1'b0;
    raddr_a     = '0;
    raddr_b     = '0;
    done        = 1'b0;
    done_status = STATUS_OK;
    cmd_take_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (res_cnt_q != 2'd2)) begin
          cmd_take_o = 1'b1;
          unique case (cmd_i.op)
            OP_PUSH: begin
              cnt_d = cnt_q + 1'b1;
              key_d = cmd_key_i;
              pos_d = IDX_W'(cnt_q);
              if (cnt_q == '0) begin
                we    = 1'b1;
                waddr = '0;
                wdata = cmd_key_i;
                done  = 1'b1;
              end else begin
                re_a    = 1'b1;
                raddr_a = IDX_W'((cnt_q - 1'b1) >> 1);
                state_d = ST_UP;
              end
            end
            OP_POP: begin
              cnt_d = cnt_q - 1'b1;
              pos_d = '0;
              if (cnt_q == CNT_W'(1)) begin
                done = 1'b1;
              end else begin
                re_a    = 1'b1;
                raddr_a = IDX_W'(cnt_q - 1'b1);
                state_d = ST_LOAD;
              end
            end
            default: begin
              done        = 1'b1;
              done_status = cmd_i.status;
            end
          endcase
        end
      end
      ST_UP: begin
        we = 1'b1;
        if (rd_a_q > key_q) begin
          wdata = rd_a_q;
          pos_d = parent;
          if (parent == '0) begin
            state_d = ST_FINAL;
          end else begin
            re_a    = 1'b1;
            raddr_a = IDX_W'((parent - 1'b1) >> 1);
          end
        end else begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        key_d   = rd_a_q;
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = IDX_W'(1);
        raddr_b = IDX_W'(2);
        state_d = ST_DOWN;
      end
      ST_DOWN: begin
        we = 1'b1;
        if (best == pos_q) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          wdata   = best_val;
          pos_d   = best;
          re_a    = 1'b1;
          re_b    = 1'b1;
          raddr_a = nleft[IDX_W-1:0];
          raddr_b = IDX_W'(nleft + 1'b1);
        end
      end
      ST_FINAL: begin
        we      = 1'b1;
        done    = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Track the root alongside every store write
  assign root_d = (we && (waddr == '0)) ? wdata : root_q;

  always_comb begin
    res_item.top_valid   = (cnt_d != '0);
    res_item.top_key     = res_item.top_valid ? 32'(root_d) : '0;
    res_item.entry_count = 11'(cnt_d);
    res_item.status      = done_status;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a_q <= mem[raddr_a];
    end
    if (re_b) begin
      rd_b_q <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    key_q  <= key_d;
    root_q <= root_d;
  end

  // Result queue
  assign empty_o    = (res_cnt_q == 2'd0);
  assign out_item_o = res_q[res_rd_q];
  assign res_pop    = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= '0;
    end else begin
      res_cnt_q <= 2'(res_cnt_q + {1'b0, done} - {1'b0, res_pop});
      if (done) begin
        res_wr_q <= !res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= !res_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q[res_wr_q] <= res_item;
    end
  end

endmodule

// ----- hdl/binary_min_heap_queue.sv -----
// Push runs a sift-up; pop loads the last entry into the root and runs a sift-down.
// A sift moves at most log2(CAPACITY) levels. A push into an empty heap, a pop of the
// last entry or a rejected request needs no sift. Requests wait in the command queue;
// one request is in the engine at a time, paced by the one-write, two-read key
// store walking one level a cycle. Reset clears the queues and the fill count at
// once; the key store is not cleared, since keys from unfilled slots are never used.
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue of signed keys kept as a binary min-heap. Each request either
// pushes a key or pops the minimum and yields one result: minimum, count and
// status.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bmhq_pkg::in_item_t    in_item_i,
  output logic                  full_o,
  output logic                  empty_o,
  output bmhq_pkg::out_item_t   out_item_o,
  input  logic                  pop_i
);
  import bmhq_pkg::*;

  // Front to engine link
  logic                 cmd_valid;
  cmd_t                 cmd;
  logic [KEY_WIDTH-1:0] cmd_key;
  logic                 cmd_take;

  // Front: accept the request, settle its status against the predicted fill
  // level, and hold it in the command queue until the engine is free.
  bmhq_front #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .in_item_i   (in_item_i),
    .full_o      (full_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_key_o   (cmd_key),
    .cmd_take_i  (cmd_take)
  );

  // Engine: run the sift on the key store and queue the result; it takes a
  // new command only while its result queue has room for the outcome.
  bmhq_engine #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_key_i   (cmd_key),
    .cmd_take_o  (cmd_take),
    .empty_o     (empty_o),
    .out_item_o  (out_item_o),
    .pop_i       (pop_i)
  );

  // A pop on an empty heap leaves it empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (out_item_o.status == STATUS_POP_EMPTY)) |-> !out_item_o.top_valid)
    else $error("pop on empty reported a valid minimum");

  // A dropped push means the heap was full, hence not empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (out_item_o.status == STATUS_PUSH_FULL)) |-> out_item_o.top_valid)
    else $error("push when full reported an empty heap");

  // The engine only takes a command the front offers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> cmd_valid)
    else $error("engine took a command from an empty queue");

endmodule
